/* rtl/ptl_pkg.sv */
// ----------------------------------------------------------------------------
// ptl_pkg
// shared types, token kinds and defaults for the line tokenizer
// ----------------------------------------------------------------------------
package ptl_pkg;

	localparam int MAX_STRING_DEF = 512;
	localparam int LINE_MAX_DEF   = 4095;

	localparam int FIELD_W    = 12;
	localparam int KIND_W     = 3;
	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 4;

	localparam logic [KIND_W-1:0] K_NL    = 3'd0;
	localparam logic [KIND_W-1:0] K_ID    = 3'd1;
	localparam logic [KIND_W-1:0] K_NUM   = 3'd2;
	localparam logic [KIND_W-1:0] K_DQ    = 3'd3;
	localparam logic [KIND_W-1:0] K_SQ    = 3'd4;
	localparam logic [KIND_W-1:0] K_PUNCT = 3'd5;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPMAX = 8'h20;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BS    = 8'h5C;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] space_len;
		logic [FIELD_W-1:0] token_start;
		logic [FIELD_W-1:0] token_len;
		logic               unbalanced;
		logic               too_long;
		logic               last_of_run;
	} tok_t;

	typedef struct packed {
		tok_t [MAX_RES-1:0] res;
		logic [1:0]         cnt;
	} tok_group_t;

endpackage

/* rtl/ptl_if.sv */
// ----------------------------------------------------------------------------
// ptl_byte_if / ptl_tok_if
// valid/ready channels for source bytes and tokens
// ----------------------------------------------------------------------------
interface ptl_byte_if;
	import ptl_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

interface ptl_tok_if;
	import ptl_pkg::*;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  token_kind;
	logic [FIELD_W-1:0] space_len;
	logic [FIELD_W-1:0] token_start;
	logic [FIELD_W-1:0] token_len;
	logic               unbalanced;
	logic               too_long;
	logic               last_of_run;
	modport source (output valid, output token_kind, output space_len, output token_start,
		output token_len, output unbalanced, output too_long, output last_of_run,
		input ready);
	modport sink (input valid, input token_kind, input space_len, input token_start,
		input token_len, input unbalanced, input too_long, input last_of_run,
		output ready);
endinterface

/* rtl/ptl_lexer.sv */
// ----------------------------------------------------------------------------
// ptl_lexer
// lexer state registers and per-byte next-state and token logic
// ----------------------------------------------------------------------------
module ptl_lexer #(
	parameter int MAX_STRING = ptl_pkg::MAX_STRING_DEF,
	parameter int LINE_MAX   = ptl_pkg::LINE_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          char_byte,
	output ptl_pkg::tok_group_t grp
);
	import ptl_pkg::*;

	localparam int POS_W = $clog2(LINE_MAX + 1);
	localparam logic [POS_W-1:0] LMAX = POS_W'(LINE_MAX);
	localparam logic [POS_W-1:0] ONE  = POS_W'(1);

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_ID   = 3'd1;
	localparam logic [2:0] MODE_NUM  = 3'd2;
	localparam logic [2:0] MODE_STR  = 3'd3;
	localparam logic [2:0] MODE_ESC  = 3'd4;

	logic [2:0]       mode_q, mode_d;
	logic             qd_q, qd_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] pend_q, pend_d;
	logic [POS_W-1:0] tst_q, tst_d;
	logic [POS_W-1:0] tsp_q, tsp_d;
	logic [POS_W-1:0] len_q, len_d;

	tok_t [MAX_RES-1:0] res;
	logic [1:0]         n;
	logic               newline;
	logic               fresh;
	logic               is_alpha, is_digit;
	logic [7:0]         quote;
	logic [POS_W-1:0]   len_inc;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		return (v >= LMAX) ? LMAX : v + ONE;
	endfunction

	function automatic logic [FIELD_W-1:0] f12(input logic [31:0] v);
		return v[FIELD_W-1:0];
	endfunction

	function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
		input logic [POS_W-1:0] space, input logic [POS_W-1:0] start,
		input logic [POS_W-1:0] len);
		tok_t t;
		t.kind        = kind;
		t.space_len   = f12(32'(space));
		t.token_start = f12(32'(start));
		t.token_len   = f12(32'(len));
		t.unbalanced  = 1'b0;
		t.too_long    = 1'b0;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	function automatic tok_t str_tok(input logic dq, input logic [POS_W-1:0] space,
		input logic [POS_W-1:0] start, input logic [POS_W-1:0] len, input logic unb);
		tok_t        t;
		logic [31:0] st;
		t = mk_tok(dq ? K_DQ : K_SQ, space, start, len);
		t.unbalanced = unb;
		if (32'(len) >= 32'(MAX_STRING)) begin
			st = 32'(start) + 32'(len) - 32'(MAX_STRING);
			if (st > 32'(LINE_MAX)) begin
				st = 32'(LINE_MAX);
			end
			t.too_long    = 1'b1;
			t.token_start = f12(st);
			t.token_len   = f12(32'(MAX_STRING));
		end
		return t;
	endfunction

	assign is_alpha = ((char_byte >= "a") && (char_byte <= "z")) ||
		((char_byte >= "A") && (char_byte <= "Z"));
	assign is_digit = (char_byte >= "0") && (char_byte <= "9");
	assign quote    = qd_q ? CH_DQ : CH_SQ;
	assign len_inc  = sat_inc(len_q);

	always_comb begin
		mode_d  = mode_q;
		qd_d    = qd_q;
		pend_d  = pend_q;
		tst_d   = tst_q;
		tsp_d   = tsp_q;
		len_d   = len_q;
		res     = '0;
		n       = 2'd0;
		newline = 1'b0;
		fresh   = 1'b0;
		case (mode_q)
			MODE_ID, MODE_NUM: begin
				if (is_alpha || is_digit || ((mode_q == MODE_ID) && (char_byte == CH_US))) begin
					len_d = len_inc;
				end else begin
					res[0] = mk_tok((mode_q == MODE_ID) ? K_ID : K_NUM, tsp_q, tst_q, len_q);
					n      = 2'd1;
					fresh  = 1'b1;
				end
			end
			MODE_STR: begin
				if (char_byte == quote) begin
					len_d  = len_inc;
					res[0] = str_tok(qd_q, tsp_q, tst_q, len_inc, 1'b0);
					n      = 2'd1;
					mode_d = MODE_IDLE;
				end else if (char_byte == CH_NL) begin
					res[0]  = str_tok(qd_q, tsp_q, tst_q, len_q, 1'b1);
					res[1]  = mk_tok(K_NL, '0, pos_q, ONE);
					n       = 2'd2;
					newline = 1'b1;
				end else begin
					len_d = len_inc;
					if (char_byte == CH_BS) begin
						mode_d = MODE_ESC;
					end
				end
			end
			MODE_ESC: begin
				if (char_byte == CH_NL) begin
					res[0]  = str_tok(qd_q, tsp_q, tst_q,
						(len_q != '0) ? len_q - ONE : '0, 1'b1);
					res[1]  = mk_tok(K_PUNCT, '0, (pos_q != '0) ? pos_q - ONE : '0, ONE);
					res[2]  = mk_tok(K_NL, '0, pos_q, ONE);
					n       = 2'd3;
					newline = 1'b1;
				end else begin
					len_d  = len_inc;
					mode_d = MODE_STR;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		if (fresh) begin
			mode_d = MODE_IDLE;
			if (char_byte == CH_NL) begin
				res[n]  = mk_tok(K_NL, pend_q, pos_q, ONE);
				n       = n + 2'd1;
				newline = 1'b1;
			end else if (char_byte <= CH_SPMAX) begin
				pend_d = sat_inc(pend_q);
			end else if (is_alpha || is_digit || (char_byte == CH_US) ||
				(char_byte == CH_DQ) || (char_byte == CH_SQ)) begin
				mode_d = is_digit ? MODE_NUM : (is_alpha || (char_byte == CH_US)) ? MODE_ID
					: MODE_STR;
				if ((char_byte == CH_DQ) || (char_byte == CH_SQ)) begin
					qd_d = (char_byte == CH_DQ);
				end
				tsp_d  = pend_q;
				tst_d  = pos_q;
				len_d  = ONE;
				pend_d = '0;
			end else begin
				res[n] = mk_tok(K_PUNCT, pend_q, pos_q, ONE);
				n      = n + 2'd1;
				pend_d = '0;
			end
		end

		if (newline) begin
			mode_d = MODE_IDLE;
			pos_d  = '0;
			pend_d = '0;
		end else begin
			pos_d = sat_inc(pos_q);
		end

		if (n != 2'd0) begin
			res[n - 2'd1].last_of_run = 1'b1;
		end
	end

	assign grp.res = res;
	assign grp.cnt = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			qd_q   <= 1'b0;
			pos_q  <= '0;
			pend_q <= '0;
			tst_q  <= '0;
			tsp_q  <= '0;
			len_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			qd_q   <= qd_d;
			pos_q  <= pos_d;
			pend_q <= pend_d;
			tst_q  <= tst_d;
			tsp_q  <= tsp_d;
			len_q  <= len_d;
		end
	end

endmodule

/* rtl/ptl_rfifo.sv */
// ----------------------------------------------------------------------------
// ptl_rfifo
// result queue taking up to three tokens per cycle and handing out one while ready is high
// ----------------------------------------------------------------------------
module ptl_rfifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ptl_pkg::tok_group_t grp,
	output logic                room,
	output logic                valid,
	input  logic                ready,
	output ptl_pkg::tok_t       head
);
	import ptl_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);
	localparam logic [CNT_W-1:0] ROOM_C  = CNT_W'(FIFO_DEPTH - MAX_RES);

	tok_t             mem [FIFO_DEPTH];
	logic [PTR_W-1:0] rd_q, wr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       push_n;
	logic             pop;

	assign push_n = push ? grp.cnt : 2'd0;
	assign pop    = valid && ready;
	assign valid  = (cnt_q != '0);
	assign room   = (cnt_q <= ROOM_C);
	assign head   = mem[rd_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push_n) begin
				mem[wr_q + PTR_W'(i)] <= grp.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push_n);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("result queue over depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (CNT_W'(push_n) + cnt_q <= DEPTH_C))
		else $error("tokens pushed without room");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !ready) |=> (valid && $stable(head)))
		else $error("stalled token lost");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> grp.res[push_n - 2'd1].last_of_run)
		else $error("last token of a byte not marked");

endmodule

/* rtl/preprocessor_line_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// preprocessor_line_tokenizer_core
// lexes source bytes into tokens with space, offset and length
//
//   port     dir   request
//   chars    sink  one source byte
//   tokens   src   one token (kind, space, start, length, flags)
//
// one byte is taken per cycle when the result queue has room for three tokens
// a byte yields zero to three tokens, drained one per cycle from a 4-entry queue while tokens.ready is high
// a byte's tokens are registered in the queue before they are offered on tokens
// reset clears lexer state and empties the queue
// a stall on tokens lets the queue fill past one entry and then holds chars.ready low
// ----------------------------------------------------------------------------
module preprocessor_line_tokenizer_core #(
	parameter int MAX_STRING = ptl_pkg::MAX_STRING_DEF,
	parameter int LINE_MAX   = ptl_pkg::LINE_MAX_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ptl_byte_if.sink chars,
	ptl_tok_if.source tokens
);
	import ptl_pkg::*;

	tok_group_t grp;
	tok_t       head;
	logic       room;
	logic       fire;

	assign chars.ready = room;
	assign fire        = chars.valid && room;

	ptl_lexer #(
		.MAX_STRING(MAX_STRING),
		.LINE_MAX  (LINE_MAX)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.char_byte(chars.char_byte),
		.grp      (grp)
	);

	ptl_rfifo u_rfifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire),
		.grp   (grp),
		.room  (room),
		.valid (tokens.valid),
		.ready (tokens.ready),
		.head  (head)
	);

	assign tokens.token_kind  = head.kind;
	assign tokens.space_len   = head.space_len;
	assign tokens.token_start = head.token_start;
	assign tokens.token_len   = head.token_len;
	assign tokens.unbalanced  = head.unbalanced;
	assign tokens.too_long    = head.too_long;
	assign tokens.last_of_run = head.last_of_run;

endmodule
